[rtl/hak_pkg.sv]
// Package for the hunt-and-kill maze stepper.
// Holds field widths, event, side, direction and register codes, and the row scan result type.
// No dependencies; every other file of the block imports it.
package hak_pkg;

	localparam int ACTION_W = 1;
	localparam int RANDOM_W = 32;
	localparam int EVENT_W  = 3;
	localparam int COORD_W  = 5;
	localparam int SIDE_W   = 2;
	localparam int CFG_W    = 6;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam int DEF_MAX_WIDTH  = 32;
	localparam int DEF_MAX_HEIGHT = 32;

	localparam logic [CFG_W-1:0] GRID_RESET = 6'd32;

	// Register decode on the word address bit of paddr.
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	localparam logic [ACTION_W-1:0] ACT_STEP  = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 1'b1;

	localparam logic [EVENT_W-1:0] EV_SEEDED  = 3'd0;
	localparam logic [EVENT_W-1:0] EV_WALK    = 3'd1;
	localparam logic [EVENT_W-1:0] EV_DEAD    = 3'd2;
	localparam logic [EVENT_W-1:0] EV_HUNT    = 3'd3;
	localparam logic [EVENT_W-1:0] EV_DONE    = 3'd4;
	localparam logic [EVENT_W-1:0] EV_CLEARED = 3'd5;

	localparam logic [SIDE_W-1:0] SIDE_NORTH = 2'd0;
	localparam logic [SIDE_W-1:0] SIDE_EAST  = 2'd1;
	localparam logic [SIDE_W-1:0] SIDE_SOUTH = 2'd2;
	localparam logic [SIDE_W-1:0] SIDE_WEST  = 2'd3;

	// Candidate order of the walk phase.
	localparam logic [1:0] WALK_UP    = 2'd0;
	localparam logic [1:0] WALK_RIGHT = 2'd1;
	localparam logic [1:0] WALK_DOWN  = 2'd2;
	localparam logic [1:0] WALK_LEFT  = 2'd3;

	// Candidate order of the hunt phase.
	localparam logic [1:0] HUNT_LEFT  = 2'd0;
	localparam logic [1:0] HUNT_UP    = 2'd1;
	localparam logic [1:0] HUNT_RIGHT = 2'd2;
	localparam logic [1:0] HUNT_DOWN  = 2'd3;

	// Result of scanning one row for the first huntable cell.
	typedef struct packed {
		logic       found;
		logic [3:0] cand;
	} hak_hit_t;

endpackage

[rtl/hak_req_if.sv]
// Request channel of the maze stepper: one item is one step or clear command.
// Depends on hak_pkg for the field widths.
interface hak_req_if import hak_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [RANDOM_W-1:0] random_value;

	modport source (output valid, output action, output random_value, input ready);
	modport sink (input valid, input action, input random_value, output ready);

endinterface

[rtl/hak_rsp_if.sv]
// Result channel of the maze stepper: one item per accepted request.
// Depends on hak_pkg for the field widths.
interface hak_rsp_if import hak_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [EVENT_W-1:0] event_res;
	logic               wall_valid;
	logic [COORD_W-1:0] wall_x;
	logic [COORD_W-1:0] wall_y;
	logic [SIDE_W-1:0]  wall_side;
	logic [COORD_W-1:0] cell_x;
	logic [COORD_W-1:0] cell_y;

	modport source (output valid, output event_res, output wall_valid, output wall_x,
		output wall_y, output wall_side, output cell_x, output cell_y, input ready);
	modport sink (input valid, input event_res, input wall_valid, input wall_x,
		input wall_y, input wall_side, input cell_x, input cell_y, output ready);

endinterface

[rtl/hunt_and_kill_maze_stepper.sv]
// Top level of the hunt-and-kill maze stepper: APB register port, row memory and step sequencer.
// Depends on hak_pkg, hak_req_if, hak_rsp_if and hak_row_scan.
//
// The block advances a hunt-and-kill maze one step per request item and returns exactly one
// result item for each. The visited map is kept as one row of MAX_WIDTH bits per memory entry
// in a single-port synchronous memory with a registered read; a flip-flop valid bit per
// row makes a clear take effect at once, so there is no clearing pass after reset or clear.
// A walk step reads the rows above, at and below the walk cell one after another through the
// memory port, then makes the neighbor choice and writes the new cell back. A hunt step
// streams the rows from the top, one row per cycle, through the same port, and stops at the
// first row with a huntable cell or, for a complete or seed result, at the last row of the grid.
// A new item is taken once the previous one has placed its result in the output register;
// that result may still be waiting on the consumer. Configuration writes grid_width at byte
// address 0 and grid_height at byte address 4; a size of 0 acts as 1 and a size beyond the
// maximum acts as the maximum.
module hunt_and_kill_maze_stepper import hak_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	hak_req_if.sink            step_req,
	hak_rsp_if.source          step_rsp
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam logic [MAX_WIDTH-1:0] ROW_ONE = MAX_WIDTH'(1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_WALK0,
		S_WALK1,
		S_WALK2,
		S_WALK3,
		S_HUNT0,
		S_HUNT1,
		S_HUNT2
	} state_t;

	typedef struct packed {
		logic [EVENT_W-1:0] ev;
		logic               wv;
		logic [COORD_W-1:0] wx;
		logic [COORD_W-1:0] wy;
		logic [SIDE_W-1:0]  ws;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
	} result_t;

	// Remainder of a 32-bit word by three: base-4 digits are summed, since 4 is 1 modulo 3.
	function automatic logic [1:0] mod3(input logic [RANDOM_W-1:0] v);
		logic [3:0] g0, g1, g2, g3;
		logic [5:0] s;
		logic [3:0] t;
		begin
			g0 = '0;
			g1 = '0;
			g2 = '0;
			g3 = '0;
			for (int i = 0; i < 4; i++) begin
				g0 = g0 + 4'(v[2*i +: 2]);
				g1 = g1 + 4'(v[8 + 2*i +: 2]);
				g2 = g2 + 4'(v[16 + 2*i +: 2]);
				g3 = g3 + 4'(v[24 + 2*i +: 2]);
			end
			s = 6'(g0) + 6'(g1) + 6'(g2) + 6'(g3);
			t = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
			if (t >= 4'd6) begin
				t = t - 4'd6;
			end else if (t >= 4'd3) begin
				t = t - 4'd3;
			end
			return t[1:0];
		end
	endfunction

	// Picks the candidate whose rank equals the random word modulo the candidate count.
	function automatic logic [1:0] pick_dir(input logic [3:0] c, input logic [1:0] m3,
		input logic [1:0] lo);
		logic [2:0] n;
		logic [2:0] r;
		logic [2:0] seen;
		logic [1:0] k;
		begin
			n = 3'($countones(c));
			case (n)
				3'd2:    r = {2'b00, lo[0]};
				3'd3:    r = {1'b0, m3};
				3'd4:    r = {1'b0, lo};
				default: r = '0;
			endcase
			seen = '0;
			k = '0;
			for (int i = 0; i < 4; i++) begin
				if (c[i]) begin
					if (seen == r) begin
						k = 2'(i);
					end
					seen = seen + 3'd1;
				end
			end
			return k;
		end
	endfunction

	function automatic logic [COORD_W-1:0] x_out(input logic [XW-1:0] v);
		logic [31:0] t;
		begin
			t = 32'(v);
			return t[COORD_W-1:0];
		end
	endfunction

	function automatic logic [COORD_W-1:0] y_out(input logic [YW-1:0] v);
		logic [31:0] t;
		begin
			t = 32'(v);
			return t[COORD_W-1:0];
		end
	endfunction

	// Configuration registers and their effective values.
	logic [CFG_W-1:0] grid_width_q, grid_height_q;
	logic [XW:0]      eff_w;
	logic [YW:0]      eff_h;
	logic [MAX_WIDTH-1:0] col_mask;

	// Sequencer state.
	state_t          state_q;
	logic            walk_active_q;
	logic [XW-1:0]   walk_x_q;
	logic [YW-1:0]   walk_y_q;
	logic [1:0]      rnd_m3_q;
	logic [1:0]      rnd_lo_q;
	logic [YW-1:0]   e_q;
	logic            any_q;
	logic [MAX_WIDTH-1:0] up_q, mid_q, row0_q;
	logic [MAX_HEIGHT-1:0] row_vld_q;

	// Output register.
	logic    out_vld_q;
	result_t out_q;

	// Visited-row memory and its read stage.
	logic [MAX_WIDTH-1:0] vmem [MAX_HEIGHT];
	logic [MAX_WIDTH-1:0] rdata_s1;
	logic                 rvld_s1;
	logic [MAX_WIDTH-1:0] rd_eff;
	logic                 rd_en, wr_en;
	logic [YW-1:0]        rd_addr, wr_addr;
	logic [MAX_WIDTH-1:0] wr_data;

	// Step evaluation.
	logic          accept, out_free, out_load;
	result_t       res;
	logic          walk_in_grid, up_ok_w, dn_ok_w, rt_ok_w, lf_ok_w;
	logic [MAX_WIDTH-1:0] mid_sr, mid_sl, walk_base;
	logic [3:0]    walk_cand;
	logic [1:0]    walk_dir, hunt_dir;
	logic [XW-1:0] walk_nx;
	logic [YW-1:0] walk_ny;
	logic          hunt_last, any_now;
	logic [YW:0]   e_plus2;
	hak_hit_t      hit;
	logic [XW-1:0] hit_x;
	logic [XW-1:0] hunt_wx;
	logic [YW-1:0] hunt_wy;
	logic [SIDE_W-1:0] hunt_ws;

	// ---------------------------------------------------------------- register port
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_q);
			REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_RESET;
			grid_height_q <= GRID_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[CFG_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[CFG_W-1:0];
			endcase
		end
	end

	// A size of zero acts as one column or row; sizes beyond the array are clamped.
	always_comb begin
		if (grid_width_q == '0) begin
			eff_w = (XW+1)'(1);
		end else if (int'(grid_width_q) > MAX_WIDTH) begin
			eff_w = (XW+1)'(MAX_WIDTH);
		end else begin
			eff_w = (XW+1)'(grid_width_q);
		end
		if (grid_height_q == '0) begin
			eff_h = (YW+1)'(1);
		end else if (int'(grid_height_q) > MAX_HEIGHT) begin
			eff_h = (YW+1)'(MAX_HEIGHT);
		end else begin
			eff_h = (YW+1)'(grid_height_q);
		end
		for (int i = 0; i < MAX_WIDTH; i++) begin
			col_mask[i] = (i < int'(eff_w));
		end
	end

	// ---------------------------------------------------------------- row memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			vmem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= vmem[rd_addr];
			rvld_s1  <= row_vld_q[rd_addr];
		end
	end

	// A row that was never written since the last clear reads as all unvisited.
	assign rd_eff = rdata_s1 & {MAX_WIDTH{rvld_s1}};

	// ---------------------------------------------------------------- handshake
	assign step_req.ready      = (state_q == S_IDLE);
	assign accept              = step_req.valid && step_req.ready;
	assign out_free            = !out_vld_q || step_rsp.ready;
	assign step_rsp.valid      = out_vld_q;
	assign step_rsp.event_res  = out_q.ev;
	assign step_rsp.wall_valid = out_q.wv;
	assign step_rsp.wall_x     = out_q.wx;
	assign step_rsp.wall_y     = out_q.wy;
	assign step_rsp.wall_side  = out_q.ws;
	assign step_rsp.cell_x     = out_q.cx;
	assign step_rsp.cell_y     = out_q.cy;

	// ---------------------------------------------------------------- walk evaluation
	always_comb begin
		walk_in_grid = ({1'b0, walk_x_q} < eff_w) && ({1'b0, walk_y_q} < eff_h);
		up_ok_w = (walk_y_q != '0);
		dn_ok_w = (({1'b0, walk_y_q} + (YW+1)'(1)) < eff_h);
		rt_ok_w = (({1'b0, walk_x_q} + (XW+1)'(1)) < eff_w);
		lf_ok_w = (walk_x_q != '0);
		mid_sr  = mid_q >> 1;
		mid_sl  = mid_q << 1;
		// In S_WALK3 the read stage holds the row below the walk cell.
		walk_cand[WALK_UP]    = up_ok_w & ~up_q[walk_x_q];
		walk_cand[WALK_RIGHT] = rt_ok_w & ~mid_sr[walk_x_q];
		walk_cand[WALK_DOWN]  = dn_ok_w & ~rd_eff[walk_x_q];
		walk_cand[WALK_LEFT]  = lf_ok_w & ~mid_sl[walk_x_q];
		walk_dir = pick_dir(walk_cand, rnd_m3_q, rnd_lo_q);
		walk_nx   = walk_x_q;
		walk_ny   = walk_y_q;
		walk_base = mid_q;
		case (walk_dir)
			WALK_UP: begin
				walk_ny   = walk_y_q - YW'(1);
				walk_base = up_q;
			end
			WALK_RIGHT: walk_nx = walk_x_q + XW'(1);
			WALK_DOWN: begin
				walk_ny   = walk_y_q + YW'(1);
				walk_base = rd_eff;
			end
			default: walk_nx = walk_x_q - XW'(1);
		endcase
	end

	// ---------------------------------------------------------------- hunt evaluation
	assign hunt_last = (({1'b0, e_q} + (YW+1)'(1)) == eff_h);
	assign e_plus2   = {1'b0, e_q} + (YW+1)'(2);
	assign any_now   = any_q || ((mid_q & col_mask) != '0);

	hak_row_scan #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_row_scan (
		.up_row   (up_q),
		.mid_row  (mid_q),
		.dn_row   (rd_eff),
		.up_ok    (e_q != '0),
		.dn_ok    (!hunt_last),
		.col_mask (col_mask),
		.hit      (hit),
		.hit_x    (hit_x)
	);

	// The wall is opened on the visited neighbor, facing the found cell.
	always_comb begin
		hunt_dir = pick_dir(hit.cand, rnd_m3_q, rnd_lo_q);
		hunt_wx  = hit_x;
		hunt_wy  = e_q;
		case (hunt_dir)
			HUNT_LEFT: begin
				hunt_wx = hit_x - XW'(1);
				hunt_ws = SIDE_EAST;
			end
			HUNT_UP: begin
				hunt_wy = e_q - YW'(1);
				hunt_ws = SIDE_SOUTH;
			end
			HUNT_RIGHT: begin
				hunt_wx = hit_x + XW'(1);
				hunt_ws = SIDE_WEST;
			end
			default: begin
				hunt_wy = e_q + YW'(1);
				hunt_ws = SIDE_NORTH;
			end
		endcase
	end

	// ---------------------------------------------------------------- memory control and result
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = walk_y_q;
		wr_en    = 1'b0;
		wr_addr  = walk_y_q;
		wr_data  = mid_q;
		out_load = 1'b0;
		res      = '0;
		unique case (state_q)
			S_IDLE: ;
			S_CLEAR: begin
				out_load = out_free;
				res.ev   = EV_CLEARED;
			end
			S_WALK0: begin
				if (walk_in_grid) begin
					rd_en   = 1'b1;
					rd_addr = up_ok_w ? (walk_y_q - YW'(1)) : walk_y_q;
				end else begin
					// The grid shrank below the walk cell.
					out_load = out_free;
					res.ev   = EV_DEAD;
					res.cx   = x_out(walk_x_q);
					res.cy   = y_out(walk_y_q);
				end
			end
			S_WALK1: begin
				rd_en   = 1'b1;
				rd_addr = walk_y_q;
			end
			S_WALK2: begin
				rd_en   = 1'b1;
				rd_addr = dn_ok_w ? (walk_y_q + YW'(1)) : walk_y_q;
			end
			S_WALK3: begin
				out_load = out_free;
				if (walk_cand == '0) begin
					res.ev = EV_DEAD;
					res.cx = x_out(walk_x_q);
					res.cy = y_out(walk_y_q);
				end else begin
					wr_en   = out_free;
					wr_addr = walk_ny;
					wr_data = walk_base | (ROW_ONE << walk_nx);
					res.ev  = EV_WALK;
					res.wv  = 1'b1;
					res.wx  = x_out(walk_x_q);
					res.wy  = y_out(walk_y_q);
					res.ws  = walk_dir;
					res.cx  = x_out(walk_nx);
					res.cy  = y_out(walk_ny);
				end
			end
			S_HUNT0: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			S_HUNT1: begin
				rd_en   = (eff_h > (YW+1)'(1));
				rd_addr = YW'(1);
			end
			S_HUNT2: begin
				if (hit.found) begin
					out_load = out_free;
					wr_en    = out_free;
					wr_addr  = e_q;
					wr_data  = mid_q | (ROW_ONE << hit_x);
					res.ev   = EV_HUNT;
					res.wv   = 1'b1;
					res.wx   = x_out(hunt_wx);
					res.wy   = y_out(hunt_wy);
					res.ws   = hunt_ws;
					res.cx   = x_out(hit_x);
					res.cy   = y_out(e_q);
				end else if (hunt_last) begin
					out_load = out_free;
					if (any_now) begin
						res.ev = EV_DONE;
					end else begin
						// Nothing inside the grid is visited yet: seed the walk at the origin.
						wr_en   = out_free;
						wr_addr = '0;
						wr_data = row0_q | ROW_ONE;
						res.ev  = EV_SEEDED;
					end
				end else if (e_plus2 < eff_h) begin
					rd_en   = 1'b1;
					rd_addr = e_plus2[YW-1:0];
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			walk_active_q <= 1'b0;
			walk_x_q      <= '0;
			walk_y_q      <= '0;
			rnd_m3_q      <= '0;
			rnd_lo_q      <= '0;
			e_q           <= '0;
			any_q         <= 1'b0;
			up_q          <= '0;
			mid_q         <= '0;
			row0_q        <= '0;
			row_vld_q     <= '0;
			out_vld_q     <= 1'b0;
			out_q         <= '0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
				out_q     <= res;
			end else if (step_rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rnd_m3_q <= mod3(step_req.random_value);
						rnd_lo_q <= step_req.random_value[1:0];
						if (step_req.action == ACT_CLEAR) begin
							state_q <= S_CLEAR;
						end else if (walk_active_q) begin
							state_q <= S_WALK0;
						end else begin
							state_q <= S_HUNT0;
						end
					end
				end
				S_CLEAR: begin
					if (out_free) begin
						row_vld_q     <= '0;
						walk_active_q <= 1'b0;
						walk_x_q      <= '0;
						walk_y_q      <= '0;
						state_q       <= S_IDLE;
					end
				end
				S_WALK0: begin
					if (walk_in_grid) begin
						state_q <= S_WALK1;
					end else if (out_free) begin
						walk_active_q <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				S_WALK1: begin
					up_q    <= rd_eff;
					state_q <= S_WALK2;
				end
				S_WALK2: begin
					mid_q   <= rd_eff;
					state_q <= S_WALK3;
				end
				S_WALK3: begin
					if (out_free) begin
						if (walk_cand == '0) begin
							walk_active_q <= 1'b0;
						end else begin
							walk_x_q <= walk_nx;
							walk_y_q <= walk_ny;
						end
						state_q <= S_IDLE;
					end
				end
				S_HUNT0: begin
					state_q <= S_HUNT1;
				end
				S_HUNT1: begin
					mid_q   <= rd_eff;
					row0_q  <= rd_eff;
					up_q    <= '0;
					e_q     <= '0;
					any_q   <= 1'b0;
					state_q <= S_HUNT2;
				end
				S_HUNT2: begin
					if (hit.found) begin
						if (out_free) begin
							walk_active_q <= 1'b1;
							walk_x_q      <= hit_x;
							walk_y_q      <= e_q;
							state_q       <= S_IDLE;
						end
					end else if (hunt_last) begin
						if (out_free) begin
							if (!any_now) begin
								walk_active_q <= 1'b1;
								walk_x_q      <= '0;
								walk_y_q      <= '0;
							end
							state_q <= S_IDLE;
						end
					end else begin
						// Slide the three-row window down by one row.
						any_q <= any_now;
						up_q  <= mid_q;
						mid_q <= rd_eff;
						e_q   <= e_q + YW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- assertions
`ifndef ASSERT_OFF
	a_write_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> out_load)
		else $error("row memory written without a result being delivered");

	a_clear_empties_map: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && out_free) |=> (row_vld_q == '0))
		else $error("clear left visited rows behind");

	a_wall_matches_event: assert property (@(posedge clk) disable iff (!arst_n)
		step_rsp.valid |-> (step_rsp.wall_valid ==
			(step_rsp.event_res == EV_WALK || step_rsp.event_res == EV_HUNT)))
		else $error("wall flag disagrees with event");

	a_no_wall_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(step_rsp.valid && !step_rsp.wall_valid) |->
			(step_rsp.wall_x == '0 && step_rsp.wall_y == '0 && step_rsp.wall_side == '0))
		else $error("wall fields set on a result without a wall");
`endif

endmodule

[rtl/hak_row_scan.sv]
// Row scanner of the hunt phase: finds the first unvisited cell of a row with a visited neighbor.
// Depends on hak_pkg for hak_hit_t and the hunt direction codes.
module hak_row_scan import hak_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int XW = $clog2(MAX_WIDTH)
) (
	input  logic [MAX_WIDTH-1:0] up_row,
	input  logic [MAX_WIDTH-1:0] mid_row,
	input  logic [MAX_WIDTH-1:0] dn_row,
	input  logic                 up_ok,
	input  logic                 dn_ok,
	input  logic [MAX_WIDTH-1:0] col_mask,
	output hak_hit_t             hit,
	output logic [XW-1:0]        hit_x
);

	logic [MAX_WIDTH-1:0] m_v, u_v, d_v, lft_v, rgt_v, hit_v, low_v;

	always_comb begin
		m_v   = mid_row & col_mask;
		u_v   = up_ok ? (up_row & col_mask) : '0;
		d_v   = dn_ok ? (dn_row & col_mask) : '0;
		lft_v = m_v << 1;
		rgt_v = m_v >> 1;
		hit_v = col_mask & ~mid_row & (lft_v | u_v | rgt_v | d_v);
		// Isolate the lowest set bit, then encode it.
		low_v = hit_v & (~hit_v + MAX_WIDTH'(1));
	end

	always_comb begin
		hit_x = '0;
		for (int b = 0; b < XW; b++) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				if (((i >> b) & 1) == 1) begin
					hit_x[b] = hit_x[b] | low_v[i];
				end
			end
		end
	end

	always_comb begin
		hit.found           = |hit_v;
		hit.cand[HUNT_LEFT]  = lft_v[hit_x];
		hit.cand[HUNT_UP]    = u_v[hit_x];
		hit.cand[HUNT_RIGHT] = rgt_v[hit_x];
		hit.cand[HUNT_DOWN]  = d_v[hit_x];
	end

endmodule

[dv/tb_hunt_and_kill_maze_stepper.sv]
// Self-checking testbench for the hunt-and-kill maze stepper.
// It keeps its own copy of the visited map and walk cell, predicts every result item and checks it.
// Depends on hak_pkg, hak_req_if, hak_rsp_if and the top level hunt_and_kill_maze_stepper.
module tb_hunt_and_kill_maze_stepper import hak_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_MAX_W = DEF_MAX_WIDTH;
	localparam int GRID_MAX_H = DEF_MAX_HEIGHT;

	// No handshake of any kind for this long ends the run. The longest legal quiet stretch is
	// the deliberate result hold-off.
	localparam int WATCHDOG_LIMIT = 2000;

	// Settling time after the last drain, long enough for a full hunt scan on 32 rows.
	localparam int SETTLE_CYCLES = 40;

	localparam int RESP_HOLD_CYCLES = 250;

	// Registers are decoded on the word address bit of paddr.
	localparam logic [PADDR_W-1:0] ADDR_GRID_WIDTH  = {REG_GRID_WIDTH, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_GRID_HEIGHT = {REG_GRID_HEIGHT, 2'b00};

	typedef struct packed {
		logic [EVENT_W-1:0] event_res;
		logic               wall_valid;
		logic [COORD_W-1:0] wall_x;
		logic [COORD_W-1:0] wall_y;
		logic [SIDE_W-1:0]  wall_side;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
	} step_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	hak_req_if step_req ();
	hak_rsp_if step_rsp ();

	hunt_and_kill_maze_stepper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.step_req (step_req),
		.step_rsp (step_rsp)
	);

	// Bench copy of the maze state and the grid registers.
	bit                 visited [GRID_MAX_H][GRID_MAX_W];
	bit                 walk_on;
	logic [COORD_W-1:0] walk_col;
	logic [COORD_W-1:0] walk_row;
	logic [CFG_W-1:0]   cfg_width;
	logic [CFG_W-1:0]   cfg_height;

	// Expected results in the order their step items were accepted.
	step_result_t       pending_steps [$];
	logic [EVENT_W-1:0] last_event;

	// Percent chance of an idle burst per item on the sender and per cycle on the receiver.
	int idle_pct;
	// Cycles the receiver still has to hold off; loaded by the back-pressure test.
	int rsp_hold;
	int quiet_cycles;

	int items_sent;
	int results_checked;
	int error_count;
	int grid_settings;
	int seed_events;
	int walk_events;
	int dead_events;
	int hunt_events;
	int done_events;
	int clear_events;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A grid size of 0 acts as 1 and a size beyond the array acts as the array size.
	function automatic int span(input logic [CFG_W-1:0] size, input int limit);
		if (size == 0)
			return 1;
		return (size > limit) ? limit : int'(size);
	endfunction

	// Directions are numbered like the side codes: north, east, south, west.
	function automatic int dir_dx(input int d);
		case (d)
			SIDE_EAST: return 1;
			SIDE_WEST: return -1;
			default:   return 0;
		endcase
	endfunction

	function automatic int dir_dy(input int d);
		case (d)
			SIDE_NORTH: return -1;
			SIDE_SOUTH: return 1;
			default:    return 0;
		endcase
	endfunction

	// -1 outside the grid in use, else the visited bit of the cell.
	function automatic int probe(input int x, input int y);
		if (x < 0 || y < 0 || x >= span(cfg_width, GRID_MAX_W) || y >= span(cfg_height, GRID_MAX_H))
			return -1;
		return visited[y][x] ? 1 : 0;
	endfunction

	// Applies one accepted step item to the bench maze state and returns the result it causes.
	task automatic advance_maze(input logic [ACTION_W-1:0] act, input logic [RANDOM_W-1:0] rnd,
		output step_result_t res);
		int          w;
		int          h;
		int unsigned n;
		int          cand [4];
		int          x;
		int          y;
		int          k;
		int          d;
		int          pick;
		bit          seen_any;
		bit          found;
		w = span(cfg_width, GRID_MAX_W);
		h = span(cfg_height, GRID_MAX_H);
		res = '0;
		n = 0;
		seen_any = 1'b0;
		found = 1'b0;
		if (act == ACT_CLEAR) begin
			// A clear empties the whole array, also cells outside the grid in use.
			for (y = 0; y < GRID_MAX_H; y++)
				for (x = 0; x < GRID_MAX_W; x++)
					visited[y][x] = 1'b0;
			walk_on = 1'b0;
			walk_col = '0;
			walk_row = '0;
			res.event_res = EV_CLEARED;
		end else if (walk_on) begin
			x = int'(walk_col);
			y = int'(walk_row);
			// A walk cell left outside a shrunken grid gets no candidates and so dead-ends.
			if (x < w && y < h) begin
				visited[y][x] = 1'b1;
				for (d = 0; d < 4; d++)
					if (probe(x + dir_dx(d), y + dir_dy(d)) == 0) begin
						cand[n] = d;
						n++;
					end
			end
			if (n == 0) begin
				walk_on = 1'b0;
				res.event_res = EV_DEAD;
				res.cell_x = walk_col;
				res.cell_y = walk_row;
			end else begin
				pick = cand[rnd % n];
				res.event_res = EV_WALK;
				res.wall_valid = 1'b1;
				res.wall_x = walk_col;
				res.wall_y = walk_row;
				res.wall_side = pick[SIDE_W-1:0];
				res.cell_x = COORD_W'(x + dir_dx(pick));
				res.cell_y = COORD_W'(y + dir_dy(pick));
				visited[res.cell_y][res.cell_x] = 1'b1;
				walk_col = res.cell_x;
				walk_row = res.cell_y;
			end
		end else begin
			for (y = 0; y < h; y++)
				for (x = 0; x < w; x++)
					if (visited[y][x])
						seen_any = 1'b1;
			if (!seen_any) begin
				// Nothing visited inside the grid: the walk starts at the origin.
				visited[0][0] = 1'b1;
				walk_on = 1'b1;
				walk_col = '0;
				walk_row = '0;
				res.event_res = EV_SEEDED;
			end else begin
				for (y = 0; y < h && !found; y++)
					for (x = 0; x < w && !found; x++)
						if (!visited[y][x]) begin
							n = 0;
							// Hunt order left, up, right, down is the walk order turned back by one.
							for (k = 0; k < 4; k++) begin
								d = (k + 3) % 4;
								if (probe(x + dir_dx(d), y + dir_dy(d)) == 1) begin
									cand[n] = d;
									n++;
								end
							end
							if (n != 0) begin
								found = 1'b1;
								pick = cand[rnd % n];
								visited[y][x] = 1'b1;
								walk_on = 1'b1;
								walk_col = COORD_W'(x);
								walk_row = COORD_W'(y);
								res.event_res = EV_HUNT;
								res.wall_valid = 1'b1;
								res.wall_x = COORD_W'(x + dir_dx(pick));
								res.wall_y = COORD_W'(y + dir_dy(pick));
								// The wall is opened on the neighbor, facing back to the found cell.
								d = (pick + 2) % 4;
								res.wall_side = d[SIDE_W-1:0];
								res.cell_x = COORD_W'(x);
								res.cell_y = COORD_W'(y);
							end
						end
				if (!found)
					res.event_res = EV_DONE;
			end
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] ERROR: %s", $realtime, what);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is %0d, expected %0d", results_checked, name,
				got, want));
	endtask

	// Offers one step item, with an optional idle burst before it, and records its expected
	// result once the block accepts it. valid is left high so that the next call can follow
	// without a gap; callers that stop sending drop it through rest_requests.
	task automatic send_step(input logic [ACTION_W-1:0] act, input logic [RANDOM_W-1:0] rnd);
		step_result_t exp_res;
		int           gap;
		@(negedge clk);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 8);
			step_req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		step_req.valid = 1'b1;
		step_req.action = act;
		step_req.random_value = rnd;
		@(posedge clk);
		while (!step_req.ready)
			@(posedge clk);
		advance_maze(act, rnd, exp_res);
		pending_steps.insert(pending_steps.size(), exp_res);
		last_event = exp_res.event_res;
		items_sent++;
	endtask

	task automatic rest_requests();
		@(negedge clk);
		step_req.valid = 1'b0;
	endtask

	// The sender stops until every expected result has come back.
	task automatic drain_results();
		rest_requests();
		while (pending_steps.size() != 0)
			@(posedge clk);
	endtask

	// One APB write: setup cycle, then access cycle; the register takes the value at the edge
	// where the access completes.
	task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == ADDR_GRID_WIDTH)
			cfg_width = data[CFG_W-1:0];
		else
			cfg_height = data[CFG_W-1:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Grid changes only happen with the block idle. The upper data bits carry noise, since only
	// the low six bits belong to the register.
	task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		drain_results();
		repeat (4) @(negedge clk);
		write_register(ADDR_GRID_WIDTH, ($urandom & ~32'h3f) | w);
		write_register(ADDR_GRID_HEIGHT, ($urandom & ~32'h3f) | h);
		grid_settings++;
	endtask

	// Every event, every size extreme, a walk stranded by a shrinking grid, visited cells left
	// outside the grid, and a completed maze that keeps reporting completion.
	task automatic test_directed();
		idle_pct = 20;
		// Default 32 x 32 grid after reset.
		send_step(ACT_STEP, 32'h0000_0000);
		send_step(ACT_STEP, 32'hffff_ffff);
		send_step(ACT_STEP, 32'h0000_0000);
		send_step(ACT_STEP, 32'h8000_0000);
		send_step(ACT_CLEAR, 32'hffff_ffff);
		send_step(ACT_STEP, 32'h0000_0000);
		// Two candidates from the origin, so this moves the walk down to row 1.
		send_step(ACT_STEP, 32'h0000_0001);
		// Shrinking to one cell strands the walk outside the grid.
		set_grid(6'd1, 6'd1);
		send_step(ACT_STEP, $urandom);
		send_step(ACT_STEP, $urandom);
		send_step(ACT_STEP, $urandom);
		// Zero sizes act as one cell.
		set_grid(6'd0, 6'd0);
		send_step(ACT_STEP, $urandom);
		send_step(ACT_CLEAR, 32'h0000_0000);
		send_step(ACT_STEP, $urandom);
		send_step(ACT_STEP, $urandom);
		send_step(ACT_STEP, $urandom);
		// Oversized values act as the full array; the hunt picks up next to the origin.
		set_grid(6'd63, 6'd33);
		send_step(ACT_STEP, 32'hffff_ffff);
		send_step(ACT_STEP, $urandom);
		send_step(ACT_STEP, $urandom);
		// A two-cell maze runs from seed to completion.
		set_grid(6'd2, 6'd1);
		send_step(ACT_CLEAR, $urandom);
		send_step(ACT_STEP, $urandom);
		send_step(ACT_STEP, $urandom);
		send_step(ACT_STEP, $urandom);
		send_step(ACT_STEP, $urandom);
	endtask

	// Whole mazes on random grid settings, mostly small, with random choices and the odd clear.
	// Some phases keep the old map, so the grid grows or shrinks under a running maze.
	task automatic test_random_mazes(input int item_budget);
		int                  stop_at;
		int                  phase_items;
		int                  dones;
		logic [CFG_W-1:0]    w;
		logic [CFG_W-1:0]    h;
		logic [ACTION_W-1:0] act;
		logic [RANDOM_W-1:0] rnd;
		stop_at = items_sent + item_budget;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0: begin
					w = 6'd32;
					h = CFG_W'($urandom_range(1, 3));
				end
				1: begin
					w = CFG_W'($urandom_range(1, 3));
					h = 6'd32;
				end
				2: begin
					w = CFG_W'($urandom_range(33, 63));
					h = CFG_W'($urandom_range(0, 2));
				end
				3: begin
					w = CFG_W'($urandom_range(0, 2));
					h = CFG_W'($urandom_range(33, 63));
				end
				default: begin
					w = CFG_W'($urandom_range(1, 8));
					h = CFG_W'($urandom_range(1, 8));
				end
			endcase
			set_grid(w, h);
			case ($urandom_range(0, 2))
				0:       idle_pct = 0;
				1:       idle_pct = 10;
				default: idle_pct = 30;
			endcase
			if ($urandom_range(0, 3) != 0)
				send_step(ACT_CLEAR, $urandom);
			phase_items = 0;
			dones = 0;
			while (dones < 2 && phase_items < 160 && items_sent < stop_at) begin
				act = ($urandom_range(0, 49) == 0) ? ACT_CLEAR : ACT_STEP;
				case ($urandom_range(0, 7))
					0:       rnd = 32'h0000_0000;
					1:       rnd = 32'hffff_ffff;
					2:       rnd = $urandom_range(0, 7);
					default: rnd = $urandom;
				endcase
				send_step(act, rnd);
				if (last_event == EV_DONE)
					dones++;
				phase_items++;
			end
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering items, so the
	// output register fills and the request side stalls. Then the sender waits for all results.
	task automatic test_backpressure();
		int i;
		idle_pct = 0;
		set_grid(6'd4, 6'd4);
		send_step(ACT_CLEAR, $urandom);
		rsp_hold = RESP_HOLD_CYCLES;
		for (i = 0; i < 16; i++)
			send_step(ACT_STEP, $urandom);
		drain_results();
		for (i = 0; i < 8; i++)
			send_step(ACT_STEP, $urandom);
	endtask

	// Last part of the run: back-to-back items with both sides always ready.
	task automatic test_steady_tail();
		int i;
		idle_pct = 0;
		set_grid(6'd6, 6'd5);
		send_step(ACT_CLEAR, $urandom);
		for (i = 0; i < 70; i++)
			send_step(ACT_STEP, $urandom);
	endtask

	// Receiver: random stall bursts, plus the long hold-off on request.
	initial begin
		int burst;
		burst = 0;
		step_rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold > 0) begin
				step_rsp.ready = 1'b0;
				rsp_hold--;
			end else if (burst > 0) begin
				step_rsp.ready = 1'b0;
				burst--;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				burst = $urandom_range(1, 8) - 1;
				step_rsp.ready = 1'b0;
			end else begin
				step_rsp.ready = 1'b1;
			end
		end
	end

	// Every accepted result is matched against the oldest expectation, field by field.
	always @(posedge clk) begin : check_result
		step_result_t got;
		step_result_t want;
		if (arst_n && step_rsp.valid && step_rsp.ready) begin
			got.event_res = step_rsp.event_res;
			got.wall_valid = step_rsp.wall_valid;
			got.wall_x = step_rsp.wall_x;
			got.wall_y = step_rsp.wall_y;
			got.wall_side = step_rsp.wall_side;
			got.cell_x = step_rsp.cell_x;
			got.cell_y = step_rsp.cell_y;
			if (pending_steps.size() == 0) begin
				report_mismatch($sformatf("result with event %0d arrived with no step pending",
					got.event_res));
			end else begin
				want = pending_steps.pop_front();
				check_field("event_res", 32'(got.event_res), 32'(want.event_res));
				check_field("wall_valid", 32'(got.wall_valid), 32'(want.wall_valid));
				check_field("wall_x", 32'(got.wall_x), 32'(want.wall_x));
				check_field("wall_y", 32'(got.wall_y), 32'(want.wall_y));
				check_field("wall_side", 32'(got.wall_side), 32'(want.wall_side));
				check_field("cell_x", 32'(got.cell_x), 32'(want.cell_x));
				check_field("cell_y", 32'(got.cell_y), 32'(want.cell_y));
				case (want.event_res)
					EV_SEEDED:  seed_events++;
					EV_WALK:    walk_events++;
					EV_DEAD:    dead_events++;
					EV_HUNT:    hunt_events++;
					EV_DONE:    done_events++;
					EV_CLEARED: clear_events++;
					default:    ;
				endcase
			end
			results_checked++;
		end
	end

	// Watchdog: any handshake on either channel or the register port restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (step_req.valid && step_req.ready) || (step_rsp.valid && step_rsp.ready)
			|| (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] ERROR: no handshake for %0d cycles, %0d results outstanding",
				$realtime, quiet_cycles, pending_steps.size());
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		step_req.valid = 1'b0;
		step_req.action = ACT_STEP;
		step_req.random_value = '0;
		idle_pct = 0;
		rsp_hold = 0;
		quiet_cycles = 0;
		items_sent = 0;
		results_checked = 0;
		error_count = 0;
		grid_settings = 0;
		seed_events = 0;
		walk_events = 0;
		dead_events = 0;
		hunt_events = 0;
		done_events = 0;
		clear_events = 0;
		last_event = EV_SEEDED;
		// Bench state after reset: empty map, no walk, full-size grid.
		for (int y = 0; y < GRID_MAX_H; y++)
			for (int x = 0; x < GRID_MAX_W; x++)
				visited[y][x] = 1'b0;
		walk_on = 1'b0;
		walk_col = '0;
		walk_row = '0;
		cfg_width = GRID_RESET;
		cfg_height = GRID_RESET;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_mazes(560);
		test_backpressure();
		test_steady_tail();

		// Let any stray result surface before the verdict.
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_steps.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived", pending_steps.size()));

		$display("Run covered %0d step items over %0d grid settings; %0d results checked.",
			items_sent, grid_settings, results_checked);
		$display("Events seen: %0d seeded, %0d walk, %0d dead end, %0d hunt, %0d complete, %0d clear.",
			seed_events, walk_events, dead_events, hunt_events, done_events, clear_events);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", error_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
